// ----- rtl/uleb_pkg.sv -----
// Shared types, constants and helpers for the serial line editor buffer.
// Used by every module of the block but uleb_ram; depends on nothing.
package uleb_pkg;

	localparam int LINE_DEPTH  = 32;
	localparam int ADDR_W      = $clog2(LINE_DEPTH);
	localparam int POS_W       = $clog2(LINE_DEPTH + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_RETURN    = 8'h0D;
	localparam logic [7:0] CH_ZERO      = 8'h00;

	typedef enum logic [1:0] {
		CMD_RX_NEWLINE,
		CMD_RX_BACKSPACE,
		CMD_RX_PLAIN,
		CMD_READ
	} cmd_class_t;

	typedef struct packed {
		cmd_class_t        cls;
		logic [7:0]        ch;
		logic [POS_W-1:0]  count;
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ECHO  = 2'd0,
		KIND_LINE  = 2'd1,
		KIND_EMPTY = 2'd2
	} kind_t;

	typedef struct packed {
		logic       strobe;
		kind_t      kind;
		logic [7:0] data;
		logic       last;
		logic       line_done;
		logic [7:0] last_char;
	} result_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_RX_LOOK,
		BK_RX_CAPT,
		BK_RX_NL,
		BK_RX_ECHO,
		BK_RD_PRIME,
		BK_RD_WALK,
		BK_RD_EMPTY
	} back_state_t;

	// Limits a requested read length to the store depth.
	function automatic logic [POS_W-1:0] clamp_count(input logic [5:0] req);
		logic [POS_W-1:0] n;
		if (int'(req) > LINE_DEPTH) begin
			n = POS_W'(LINE_DEPTH);
		end else begin
			n = POS_W'(req);
		end
		return n;
	endfunction

endpackage

// ----- rtl/uleb_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package dependency.
module uleb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/uleb_front.sv -----
// Front end: takes input items and classifies them into commands.
// Depends on uleb_pkg.
module uleb_front (
	input  logic                  start,
	input  logic                  op,
	input  logic [7:0]            rx_char,
	input  logic [5:0]            read_count,
	input  logic                  queue_full,
	output logic                  busy,
	output logic                  push,
	output uleb_pkg::cmd_t        cmd
);

	assign busy = queue_full;
	assign push = start && !queue_full;

	always_comb begin
		cmd.ch    = rx_char;
		cmd.count = uleb_pkg::clamp_count(read_count);
		if (op) begin
			cmd.cls = uleb_pkg::CMD_READ;
		end else if (rx_char == uleb_pkg::CH_NEWLINE) begin
			cmd.cls = uleb_pkg::CMD_RX_NEWLINE;
		end else if (rx_char == uleb_pkg::CH_BACKSPACE) begin
			cmd.cls = uleb_pkg::CMD_RX_BACKSPACE;
		end else begin
			cmd.cls = uleb_pkg::CMD_RX_PLAIN;
		end
	end

endmodule

// ----- rtl/uleb_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on uleb_pkg.
module uleb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  uleb_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output uleb_pkg::cmd_t head
);

	uleb_pkg::cmd_t                   entry_q [uleb_pkg::QUEUE_DEPTH];
	logic [uleb_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [uleb_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [uleb_pkg::QCNT_W-1:0]      count_q;

	assign full  = (count_q == uleb_pkg::QCNT_W'(uleb_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	function automatic logic [uleb_pkg::QPTR_W-1:0] next_ptr(
		input logic [uleb_pkg::QPTR_W-1:0] p);
		logic [uleb_pkg::QPTR_W-1:0] r;
		if (p == uleb_pkg::QPTR_W'(uleb_pkg::QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/uleb_back.sv -----
// Back end: executes queued commands against the line store and emits results.
// Depends on uleb_pkg and uleb_ram.
module uleb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              queue_empty,
	input  uleb_pkg::cmd_t    cmd,
	output logic              pop,
	output uleb_pkg::result_t res
);

	uleb_pkg::back_state_t                state_q, state_d;
	logic [uleb_pkg::POS_W-1:0]           fill_q;
	logic                                 done_q;
	logic [uleb_pkg::LINE_DEPTH-1:0]      valid_q;
	logic [7:0]                           fill_val_q;
	logic [7:0]                           lc_q;
	logic [7:0]                           ch_q;
	logic                                 nl_first_q;
	logic [uleb_pkg::POS_W-1:0]           rd_idx_q;
	logic [uleb_pkg::POS_W-1:0]           left_q;
	logic                                 sel_q;

	logic                                 ram_we;
	logic                                 ram_re;
	logic [uleb_pkg::ADDR_W-1:0]          ram_raddr;
	logic [7:0]                           ram_rdata;
	logic [7:0]                           entry_val;
	logic                                 has_room;
	logic [uleb_pkg::POS_W-1:0]           fill_m1;

	assign has_room  = (fill_q < uleb_pkg::POS_W'(uleb_pkg::LINE_DEPTH));
	assign fill_m1   = fill_q - 1'b1;
	// Entries not written since the last clear read as the clear value.
	assign entry_val = sel_q ? ram_rdata : fill_val_q;

	uleb_ram #(
		.WIDTH (8),
		.DEPTH (uleb_pkg::LINE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[uleb_pkg::ADDR_W-1:0]),
		.wdata (cmd.ch),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uleb_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		pop           = 1'b0;
		ram_we        = 1'b0;
		ram_re        = 1'b0;
		ram_raddr     = rd_idx_q[uleb_pkg::ADDR_W-1:0];
		res.strobe    = 1'b0;
		res.kind      = uleb_pkg::KIND_ECHO;
		res.data      = ch_q;
		res.last      = 1'b0;
		res.line_done = done_q;
		res.last_char = lc_q;
		unique case (state_q)
			uleb_pkg::BK_IDLE: begin
				if (!queue_empty) begin
					pop = 1'b1;
					unique case (cmd.cls)
						uleb_pkg::CMD_READ: begin
							state_d = (cmd.count == '0) ? uleb_pkg::BK_RD_EMPTY
							                            : uleb_pkg::BK_RD_PRIME;
						end
						uleb_pkg::CMD_RX_PLAIN: begin
							ram_we  = has_room;
							state_d = uleb_pkg::BK_RX_LOOK;
						end
						uleb_pkg::CMD_RX_NEWLINE,
						uleb_pkg::CMD_RX_BACKSPACE: begin
							state_d = uleb_pkg::BK_RX_LOOK;
						end
						default: state_d = uleb_pkg::BK_IDLE;
					endcase
				end
			end
			uleb_pkg::BK_RX_LOOK: begin
				ram_re    = 1'b1;
				ram_raddr = fill_m1[uleb_pkg::ADDR_W-1:0];
				state_d   = uleb_pkg::BK_RX_CAPT;
			end
			uleb_pkg::BK_RX_CAPT: begin
				state_d = nl_first_q ? uleb_pkg::BK_RX_NL : uleb_pkg::BK_RX_ECHO;
			end
			uleb_pkg::BK_RX_NL: begin
				res.strobe = 1'b1;
				res.data   = uleb_pkg::CH_NEWLINE;
				state_d    = uleb_pkg::BK_RX_ECHO;
			end
			uleb_pkg::BK_RX_ECHO: begin
				res.strobe = 1'b1;
				res.last   = 1'b1;
				state_d    = uleb_pkg::BK_IDLE;
			end
			uleb_pkg::BK_RD_EMPTY: begin
				res.strobe = 1'b1;
				res.kind   = uleb_pkg::KIND_EMPTY;
				res.data   = uleb_pkg::CH_ZERO;
				res.last   = 1'b1;
				state_d    = uleb_pkg::BK_IDLE;
			end
			uleb_pkg::BK_RD_PRIME: begin
				ram_re  = 1'b1;
				state_d = uleb_pkg::BK_RD_WALK;
			end
			uleb_pkg::BK_RD_WALK: begin
				ram_re     = 1'b1;
				res.strobe = 1'b1;
				res.kind   = uleb_pkg::KIND_LINE;
				res.data   = entry_val;
				res.last   = (left_q == uleb_pkg::POS_W'(1));
				if (left_q == uleb_pkg::POS_W'(1)) begin
					state_d = uleb_pkg::BK_IDLE;
				end
			end
			default: state_d = uleb_pkg::BK_IDLE;
		endcase
	end

	// Control state of the line: position, done mark, entry valid bits and clear value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			done_q     <= 1'b0;
			valid_q    <= '0;
			fill_val_q <= uleb_pkg::CH_ZERO;
		end else begin
			if (pop) begin
				unique case (cmd.cls)
					uleb_pkg::CMD_RX_NEWLINE: begin
						fill_q <= '0;
						done_q <= 1'b1;
					end
					uleb_pkg::CMD_RX_BACKSPACE: begin
						if (fill_q != '0) begin
							fill_q <= fill_m1;
						end
					end
					uleb_pkg::CMD_RX_PLAIN: begin
						if (has_room) begin
							fill_q <= fill_q + 1'b1;
							valid_q[fill_q[uleb_pkg::ADDR_W-1:0]] <= 1'b1;
						end
					end
					uleb_pkg::CMD_READ: begin
						done_q <= 1'b0;
						if (cmd.count == '0) begin
							valid_q    <= '0;
							fill_val_q <= uleb_pkg::CH_SPACE;
						end
					end
					default: done_q <= done_q;
				endcase
			end
			if (state_q == uleb_pkg::BK_RD_WALK && left_q == uleb_pkg::POS_W'(1)) begin
				valid_q    <= '0;
				fill_val_q <= uleb_pkg::CH_SPACE;
			end
		end
	end

	// Per-command working registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			ch_q       <= cmd.ch;
			nl_first_q <= (fill_q == '0);
			left_q     <= cmd.count;
			rd_idx_q   <= '0;
			if (cmd.cls == uleb_pkg::CMD_READ) begin
				lc_q <= (fill_q == '0) ? uleb_pkg::CH_RETURN : uleb_pkg::CH_SPACE;
			end
		end
		if (ram_re) begin
			sel_q <= valid_q[ram_raddr];
		end
		if (state_q == uleb_pkg::BK_RX_CAPT) begin
			lc_q <= (fill_q == '0) ? uleb_pkg::CH_RETURN : entry_val;
		end
		if (state_q == uleb_pkg::BK_RD_PRIME || state_q == uleb_pkg::BK_RD_WALK) begin
			rd_idx_q <= rd_idx_q + 1'b1;
		end
		if (state_q == uleb_pkg::BK_RD_WALK) begin
			left_q <= left_q - 1'b1;
		end
	end

endmodule

// ----- rtl/uart_line_editor_buffer_top.sv -----
// Top level of the serial line editor buffer.
// Depends on uleb_pkg, uleb_front, uleb_queue and uleb_back.
//
// Usage: an item is taken at a rising edge with start high and busy low. With
// op low, rx_char is a received byte: it is echoed (preceded by an echoed
// newline when the line is empty), and it then ends the line, erases the last
// character, or is stored if room remains. With op high, the first read_count
// stored characters are emitted (clamped to the line depth), or a single empty
// marker when read_count is zero; the store then reads back as spaces and the
// done mark clears.
// Each result shows on kind, data, last, line_done and last_char for exactly
// one cycle with result_strobe high; the receiver cannot stall, so results
// never wait. line_done and last_char give the state after the whole item.
// Flow: items wait in a two-entry command queue; busy is high only while that
// queue is full. A received byte passes RX_LOOK and RX_CAPT, the store
// lookup for the new last character, then RX_NL when the newline echo is
// added, then RX_ECHO. A read primes the single store read port in RD_PRIME,
// then emits one character per cycle from it; an empty read emits its marker
// alone. Reset empties the queue, zeroes the position and done mark, and makes
// every store entry read as zero without a clearing pass.
module uart_line_editor_buffer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       op,
	input  logic [7:0] rx_char,
	input  logic [5:0] read_count,
	output logic       result_strobe,
	output logic [1:0] kind,
	output logic [7:0] data,
	output logic       last,
	output logic       line_done,
	output logic [7:0] last_char
);

	uleb_pkg::cmd_t    front_cmd;
	uleb_pkg::cmd_t    head_cmd;
	uleb_pkg::result_t res;
	logic              push;
	logic              pop;
	logic              queue_full;
	logic              queue_empty;

	// Classifies each incoming item into a command.
	uleb_front u_front (
		.start      (start),
		.op         (op),
		.rx_char    (rx_char),
		.read_count (read_count),
		.queue_full (queue_full),
		.busy       (busy),
		.push       (push),
		.cmd        (front_cmd)
	);

	// Decouples acceptance from execution.
	uleb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (front_cmd),
		.pop      (pop),
		.full     (queue_full),
		.empty    (queue_empty),
		.head     (head_cmd)
	);

	// Executes commands against the line store.
	uleb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.cmd         (head_cmd),
		.pop         (pop),
		.res         (res)
	);

	assign result_strobe = res.strobe;
	assign kind          = res.kind;
	assign data          = res.data;
	assign last          = res.last;
	assign line_done     = res.line_done;
	assign last_char     = res.last_char;

endmodule

// ----- rtl/uleb_check.sv -----
// Port-level checker for the serial line editor buffer, bound to the top level.
// Depends on uleb_pkg and uart_line_editor_buffer_top.
module uleb_check (
	input logic       clk,
	input logic       arst_n,
	input logic       result_strobe,
	input logic [1:0] kind,
	input logic [7:0] data,
	input logic       last,
	input logic       line_done,
	input logic [7:0] last_char
);

	// Results of one item follow each other without gaps.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last |=> result_strobe)
		else $error("result train of one item has a gap");

	// Status fields are the same across all results of one item.
	a_status_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last |=> $stable(line_done) && $stable(last_char))
		else $error("status fields changed within one item");

	// The empty marker is a lone result with zero data.
	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && kind == uleb_pkg::KIND_EMPTY |-> last && data == uleb_pkg::CH_ZERO)
		else $error("empty marker malformed");

	// A read always leaves the done mark clear.
	a_read_clears_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && (kind == uleb_pkg::KIND_LINE || kind == uleb_pkg::KIND_EMPTY)
		|-> !line_done)
		else $error("done mark set after a read");

	// An echoed newline ending an item leaves an empty, completed line.
	a_newline_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && kind == uleb_pkg::KIND_ECHO && last && data == uleb_pkg::CH_NEWLINE
		|-> line_done && last_char == uleb_pkg::CH_RETURN)
		else $error("newline did not end the line");

endmodule

bind uart_line_editor_buffer_top uleb_check u_uleb_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_strobe (result_strobe),
	.kind          (kind),
	.data          (data),
	.last          (last),
	.line_done     (line_done),
	.last_char     (last_char)
);
